### rtl/image_orientation_transform_assert.svh
// Assertion macros shared by the checkers of the orientation transform.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef IMAGE_ORIENTATION_TRANSFORM_ASSERT_SVH
`define IMAGE_ORIENTATION_TRANSFORM_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define IOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition must hold in the cycle after the trigger.
`define IOT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/iot_pkg.sv
// Shared types and constants of the image orientation transform.
// No dependencies; used by the front, back and top level.
package iot_pkg;

  // Field widths
  localparam int PIX_W      = 24;
  localparam int DIM_W      = 9;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Transform modes
  localparam logic [MODE_W-1:0] MODE_HFLIP     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_VFLIP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT_180   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT_RIGHT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROT_LEFT  = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd2;

  // Per-item control carried from front to back
  typedef struct packed {
    logic bank;   // bank the item is written to
    logic valid;  // a complete previous frame exists
    logic last;   // last pixel of the frame
  } iot_flags_t;

endpackage

### rtl/iot_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module iot_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/iot_fifo.sv
// Small register FIFO with occupancy count; DEPTH is a power of two.
// No dependencies. The writer never pushes into a full FIFO.
module iot_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign pop_data  = mem[rd_ptr];
  assign not_empty = (count != '0);

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/iot_front.sv
// Front end: configuration registers, input acceptance, output raster
// counters and source address generation. Depends on iot_pkg.
module iot_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int IDX_W      = 16,
  parameter int Q_DEPTH    = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [iot_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [iot_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [iot_pkg::PIX_W-1:0]        s_tdata,
  input  logic [$clog2(Q_DEPTH+1)-1:0]     q_count,
  output logic                             push,
  output logic [iot_pkg::PIX_W-1:0]        push_pixel,
  output iot_pkg::iot_flags_t              push_flags,
  output logic [IDX_W-1:0]                 push_waddr,
  output logic [IDX_W-1:0]                 push_raddr
);

  localparam int DIM_W  = iot_pkg::DIM_W;
  localparam int DIV_CW = $clog2(IDX_W + 1);

  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_SIZE  = 2'd1;
  localparam logic [1:0] ST_CLAMP = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // Configuration registers
  logic [iot_pkg::MODE_W-1:0] mode;
  logic [DIM_W-1:0]           cfg_cols;
  logic [DIM_W-1:0]           cfg_rows;

  // Derived sizes
  logic [DIM_W-1:0] cols_e;
  logic [DIM_W-1:0] rows_e;
  logic [DIM_W-1:0] out_w;
  logic [IDX_W-1:0] last_idx;

  // Position state
  logic [1:0]       state;
  logic [IDX_W-1:0] pidx;
  logic [IDX_W-1:0] pcur;
  logic [DIM_W-1:0] row_cnt;
  logic [DIM_W-1:0] col_cnt;
  logic             wbank;
  logic             frame_ready;

  // Divider state
  logic [IDX_W-1:0]  div_q;
  logic [DIM_W-1:0]  div_rem;
  logic [DIV_CW-1:0] div_cnt;

  // Address stage
  logic                      f1_valid;
  logic [DIM_W-1:0]          f1_sr;
  logic [DIM_W-1:0]          f1_sc;
  logic [iot_pkg::PIX_W-1:0] f1_pixel;
  logic [IDX_W-1:0]          f1_waddr;
  iot_pkg::iot_flags_t       f1_flags;

  logic                   accept;
  logic                   is_last;
  logic                   rotated;
  logic [DIM_W-1:0]       cols_c;
  logic [DIM_W-1:0]       rows_c;
  logic [2*DIM_W-1:0]     total_c;
  logic [IDX_W-1:0]       pclamp;
  logic [DIM_W:0]         trial;
  logic                   q_bit;
  logic [DIM_W-1:0]       rem_next;
  logic [DIM_W-1:0]       cols_m1;
  logic [DIM_W-1:0]       rows_m1;
  logic [DIM_W-1:0]       sr;
  logic [DIM_W-1:0]       sc;
  logic [2*DIM_W-1:0]     row_base;

  // Accept while running, with room in the queue for everything in flight
  assign s_tready = (state == ST_RUN) && !cfg_we &&
                    ((32'(q_count) + 32'(f1_valid)) < Q_DEPTH);
  assign accept   = s_tvalid && s_tready;
  assign is_last  = (pcur == last_idx);

  // Size decode
  assign rotated = (mode == iot_pkg::MODE_ROT_RIGHT) || (mode == iot_pkg::MODE_ROT_LEFT);
  assign cols_c  = clamp_dim(cfg_cols, MAX_WIDTH);
  assign rows_c  = clamp_dim(cfg_rows, MAX_HEIGHT);
  assign total_c = {{DIM_W{1'b0}}, cols_c} * {{DIM_W{1'b0}}, rows_c};
  assign pclamp  = (pidx > last_idx) ? last_idx : pidx;

  // One restoring division step
  assign trial    = {div_rem, div_q[IDX_W-1]};
  assign q_bit    = (trial >= {1'b0, out_w});
  assign rem_next = q_bit ? DIM_W'(trial - {1'b0, out_w}) : DIM_W'(trial);

  // Map output position to source row and column
  assign cols_m1 = cols_e - DIM_W'(1);
  assign rows_m1 = rows_e - DIM_W'(1);

  always_comb begin
    case (mode)
      iot_pkg::MODE_HFLIP: begin
        sr = row_cnt;
        sc = cols_m1 - col_cnt;
      end
      iot_pkg::MODE_VFLIP: begin
        sr = rows_m1 - row_cnt;
        sc = col_cnt;
      end
      iot_pkg::MODE_ROT_180: begin
        sr = rows_m1 - row_cnt;
        sc = cols_m1 - col_cnt;
      end
      iot_pkg::MODE_ROT_RIGHT: begin
        sr = rows_m1 - col_cnt;
        sc = row_cnt;
      end
      iot_pkg::MODE_ROT_LEFT: begin
        sr = col_cnt;
        sc = cols_m1 - row_cnt;
      end
      default: begin
        sr = row_cnt;
        sc = col_cnt;
      end
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= iot_pkg::MODE_HFLIP;
      cfg_cols <= DIM_W'(256);
      cfg_rows <= DIM_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        iot_pkg::REG_MODE: mode     <= cfg_data[iot_pkg::MODE_W-1:0];
        iot_pkg::REG_COLS: cfg_cols <= cfg_data;
        iot_pkg::REG_ROWS: cfg_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: resize, clamp, divide, then step one pixel per item
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SIZE;
      pidx        <= '0;
      pcur        <= '0;
      row_cnt     <= '0;
      col_cnt     <= '0;
      wbank       <= 1'b0;
      frame_ready <= 1'b0;
      f1_valid    <= 1'b0;
    end else begin
      f1_valid <= accept;
      if (cfg_we) begin
        state <= ST_SIZE;
      end else begin
        case (state)
          ST_SIZE: begin
            cols_e   <= cols_c;
            rows_e   <= rows_c;
            out_w    <= rotated ? rows_c : cols_c;
            last_idx <= IDX_W'(total_c - (2*DIM_W)'(1));
            state    <= ST_CLAMP;
          end
          ST_CLAMP: begin
            pcur    <= pclamp;
            div_q   <= pclamp;
            div_rem <= '0;
            div_cnt <= '0;
            state   <= ST_DIV;
          end
          ST_DIV: begin
            div_rem <= rem_next;
            div_q   <= {div_q[IDX_W-2:0], q_bit};
            div_cnt <= div_cnt + DIV_CW'(1);
            if (div_cnt == DIV_CW'(IDX_W - 1)) begin
              row_cnt <= DIM_W'({div_q[IDX_W-2:0], q_bit});
              col_cnt <= rem_next;
              state   <= ST_RUN;
            end
          end
          ST_RUN: begin
            if (accept) begin
              if (is_last) begin
                pidx        <= '0;
                pcur        <= '0;
                row_cnt     <= '0;
                col_cnt     <= '0;
                wbank       <= ~wbank;
                frame_ready <= 1'b1;
              end else begin
                pidx <= pcur + IDX_W'(1);
                pcur <= pcur + IDX_W'(1);
                if (col_cnt == out_w - DIM_W'(1)) begin
                  col_cnt <= '0;
                  row_cnt <= row_cnt + DIM_W'(1);
                end else begin
                  col_cnt <= col_cnt + DIM_W'(1);
                end
              end
            end
          end
          default: state <= ST_SIZE;
        endcase
      end
    end
  end

  // Capture the accepted item with its source coordinates
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_sr          <= sr;
      f1_sc          <= sc;
      f1_pixel       <= s_tdata;
      f1_waddr       <= pcur;
      f1_flags.bank  <= wbank;
      f1_flags.valid <= frame_ready;
      f1_flags.last  <= is_last;
    end
  end

  // Source raster address: row times width plus column
  assign row_base   = f1_sr * cols_e;
  assign push       = f1_valid;
  assign push_pixel = f1_pixel;
  assign push_flags = f1_flags;
  assign push_waddr = f1_waddr;
  assign push_raddr = IDX_W'(row_base) + IDX_W'(f1_sc);

endmodule

### rtl/iot_back.sv
// Back end: frame store write and read, blanking and output buffering.
// Depends on iot_pkg, iot_ram and iot_fifo.
module iot_back #(
  parameter int IDX_W    = 16,
  parameter int OQ_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  logic [iot_pkg::PIX_W-1:0] q_pixel,
  input  iot_pkg::iot_flags_t       q_flags,
  input  logic [IDX_W-1:0]          q_waddr,
  input  logic [IDX_W-1:0]          q_raddr,
  output logic                      q_pop,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [iot_pkg::PIX_W-1:0] m_tdata,
  output logic                      m_tuser,
  output logic                      m_tlast
);

  localparam int PIX_W  = iot_pkg::PIX_W;
  localparam int OQ_W   = PIX_W + 2;
  localparam int OQ_CW  = $clog2(OQ_DEPTH + 1);

  logic                rd_valid;
  iot_pkg::iot_flags_t rd_flags;
  logic [PIX_W-1:0]    ram_q;
  logic [OQ_CW-1:0]    oq_count;
  logic [OQ_W-1:0]     oq_in;
  logic [OQ_W-1:0]     oq_out;
  logic                oq_pop;

  // Issue only when the output buffer has room for this read too
  assign q_pop = q_valid && ((32'(oq_count) + 32'(rd_valid)) < OQ_DEPTH);

  // Write the new pixel to its bank, read the source from the other bank
  iot_ram #(
    .WIDTH (PIX_W),
    .DEPTH (2 ** (IDX_W + 1))
  ) u_store (
    .clk   (clk),
    .we    (q_pop),
    .waddr ({q_flags.bank, q_waddr}),
    .wdata (q_pixel),
    .raddr ({~q_flags.bank, q_raddr}),
    .rdata (ram_q)
  );

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_flags <= q_flags;
    end
  end

  // Blank the pixel until a full frame is stored
  assign oq_in = {rd_flags.valid & rd_flags.last, rd_flags.valid,
                  rd_flags.valid ? ram_q : {PIX_W{1'b0}}};

  iot_fifo #(
    .WIDTH (OQ_W),
    .DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (rd_valid),
    .push_data (oq_in),
    .pop       (oq_pop),
    .pop_data  (oq_out),
    .not_empty (m_tvalid),
    .count     (oq_count)
  );

  assign oq_pop  = m_tvalid && m_tready;
  assign m_tdata = oq_out[PIX_W-1:0];
  assign m_tuser = oq_out[PIX_W];
  assign m_tlast = oq_out[PIX_W+1];

endmodule

### rtl/image_orientation_transform.sv
// An accepted pixel passes the address stage, the queue, the frame store read
// register and the output buffer. Throughput: one pixel per cycle unless the
// output stalls, set by the single write and read port pair of the frame store.
// After reset and every config write, input is held off while sizes are latched,
// the index clamped and the raster position re-derived from the pixel index by
// a one-bit-per-cycle divider. Reset is synchronous; the store keeps no reset value.
module image_orientation_transform #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [iot_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iot_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,   // in_red, in_green, in_blue
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [23:0]                    m_tdata,   // out_red, out_green, out_blue
  output logic                           m_tuser,   // out_valid
  output logic                           m_tlast    // frame_end
);

  localparam int NPIX    = MAX_WIDTH * MAX_HEIGHT;
  localparam int IDX_W   = (NPIX > 4) ? $clog2(NPIX) : 2;
  localparam int Q_DEPTH = 4;
  localparam int FL_W    = $bits(iot_pkg::iot_flags_t);
  localparam int QW      = iot_pkg::PIX_W + FL_W + 2 * IDX_W;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  logic                      push;
  logic [iot_pkg::PIX_W-1:0] push_pixel;
  iot_pkg::iot_flags_t       push_flags;
  logic [IDX_W-1:0]          push_waddr;
  logic [IDX_W-1:0]          push_raddr;
  logic [QW-1:0]             q_in;
  logic [QW-1:0]             q_out;
  logic                      q_valid;
  logic                      q_pop;
  logic [Q_CW-1:0]           q_count;

  // Front: accept and classify pixels
  iot_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .IDX_W      (IDX_W),
    .Q_DEPTH    (Q_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .q_count    (q_count),
    .push       (push),
    .push_pixel (push_pixel),
    .push_flags (push_flags),
    .push_waddr (push_waddr),
    .push_raddr (push_raddr)
  );

  // Queue between front and back
  assign q_in = {push_pixel, push_flags, push_waddr, push_raddr};

  iot_fifo #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_valid),
    .count     (q_count)
  );

  // Back: frame store access and output
  iot_back #(
    .IDX_W    (IDX_W),
    .OQ_DEPTH (Q_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pixel  (q_out[QW-1 -: iot_pkg::PIX_W]),
    .q_flags  (iot_pkg::iot_flags_t'(q_out[2*IDX_W +: FL_W])),
    .q_waddr  (q_out[IDX_W +: IDX_W]),
    .q_raddr  (q_out[IDX_W-1:0]),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### rtl/iot_checker.sv
// Port-level checks of the orientation transform, bound to the top level.
// Depends on image_orientation_transform_assert.svh.
`include "image_orientation_transform_assert.svh"

module iot_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // Frame end is only flagged on valid output
  `IOT_ASSERT_NOW(a_end_needs_valid, m_tvalid && m_tlast, m_tuser, "frame end on blank output")

  // Blank output carries zero pixel data
  `IOT_ASSERT_NOW(a_blank_is_zero, m_tvalid && !m_tuser, m_tdata == 24'd0, "blank pixel not zero")

  // A configuration write holds off input while the position is rebuilt
  `IOT_ASSERT_NEXT(a_cfg_stalls_input, cfg_we, !s_tready, "input taken right after config write")

  // Input stays held off in the cycle after reset
  `IOT_ASSERT_NOW(a_reset_stalls_input, $past(rst), !s_tready, "input taken right after reset")

  // A stalled result holds
  `IOT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

endmodule

bind image_orientation_transform iot_checker u_checker (.*);
